// File: src/lz77_hash_compressor_macros.svh
// Assertion macros for the LZ77 hash compressor.
// Used by the top level; needs a clk and an active-low rst_n in scope.
`ifndef LZ77_HASH_COMPRESSOR_MACROS_SVH
`define LZ77_HASH_COMPRESSOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LZC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzc assertion failed");

// Next-cycle implication, checked outside reset.
`define LZC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzc assertion failed");

`endif

// File: src/lzc_pkg.sv
// Shared types and constants of the LZ77 hash compressor.
// No dependencies; used by the top level, lzc_hash and lzc_packer.
package lzc_pkg;

  localparam int HISTORY_BYTES_DEF = 131072;
  localparam int HASH_BITS_MAX_DEF = 16;
  localparam int MAX_DISTANCE_DEF  = 65535;

  localparam logic [31:0] HASH_MUL   = 32'd2654435761;
  localparam logic [7:0]  TOK_EXT    = 8'hFF;
  localparam logic [7:0]  TOK_SHORT  = 8'h80;
  localparam logic [7:0]  RUN_CAP    = 8'd127;
  localparam logic [8:0]  SHORT_CAP  = 9'd129;
  localparam logic [8:0]  MIN_MATCH  = 9'd4;
  localparam logic [8:0]  MATCH_CEIL = 9'd258;
  localparam logic [4:0]  TBITS_MIN  = 5'd10;

  localparam logic [1:0] CFG_MAX_MATCH = 2'd0;
  localparam logic [1:0] CFG_ALLOW_EXT = 2'd1;
  localparam logic [1:0] CFG_TBITS     = 2'd2;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_CHECK, S_FETCH, S_HASH, S_TRD, S_TWR, S_CISS, S_CCMP,
    S_MDEC, S_LIT, S_EP, S_EP_RD, S_EP_WR, S_TOK, S_FIN, S_DONE
  } state_t;

  typedef struct packed {
    logic       byte_v;
    logic [7:0] data;
    logic       flush;
    logic       eos;
  } pk_cmd_t;

  typedef struct packed {
    logic byte_rdy;
    logic flush_rdy;
    logic has_data;
  } pk_stat_t;

endpackage

// File: src/lz77_hash_compressor.sv
// Greedy LZ77 compressor: sequencer over history ring, hash table and packer.
// Depends on lzc_pkg, lzc_ring, lzc_table, lzc_hash, lzc_packer and the macros.
//
// Usage: bytes of a stream enter on in_valid/in_stall with in_byte and
// in_last_byte; compressed bytes leave on out_valid/out_stall as 64-bit
// little-endian words with out_byte_count, out_last_of_run (last word caused
// by the input byte) and out_end_of_stream (last word of the stream).
// One input byte is taken at a time; in_stall stays high until all work for
// it is done. Per byte the sequencer accepts it, tests whether a position
// is ready, decides each position (fetch, hash, table read and write, then
// a candidate compare one byte at a time on the single byte comparator),
// moves literal bytes and count or token bytes into the packer, closes each
// literal-run pass and closes the byte. Output words appear as the packer
// fills them.
// Reset and the end of each stream start a clearing pass over all
// 2**HASH_BITS_MAX hash table entries, during which no byte is taken.
// A stalled receiver holds the output register; the sequencer waits on the
// packer and resumes when the word is taken. cfg_we writes register cfg_index.
module lz77_hash_compressor #(
  parameter int HISTORY_BYTES = lzc_pkg::HISTORY_BYTES_DEF,
  parameter int HASH_BITS_MAX = lzc_pkg::HASH_BITS_MAX_DEF,
  parameter int MAX_DISTANCE  = lzc_pkg::MAX_DISTANCE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_last_of_run,
  output logic        out_end_of_stream,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  `include "lz77_hash_compressor_macros.svh"

  localparam int AW = $clog2(HISTORY_BYTES);
  localparam int HB = HASH_BITS_MAX;
  localparam logic [31:0] MAXD = 32'(MAX_DISTANCE);
  localparam logic [4:0]  HBV  = 5'(HASH_BITS_MAX);

  lzc_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [31:0] bytes_r, bytes_nxt, scan_r, scan_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  fk_r, fk_nxt;
  logic [31:0] word_r, word_nxt;
  logic [8:0]  k_r, k_nxt, limit_r, limit_nxt, mlen_r, mlen_nxt;
  logic [31:0] cand_r, cand_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic        ext_r, ext_nxt;
  logic [2:0]  tk_r, tk_nxt;
  logic [31:0] ep_addr_r, ep_addr_nxt;
  logic [6:0]  ep_cnt_r, ep_cnt_nxt;
  logic [HB-1:0] clr_r, clr_nxt;

  logic [8:0] max_match_r;
  logic       allow_ext_r;
  logic [4:0] tbits_r;
  logic [8:0] eff_m;
  logic [4:0] eff_b;

  logic [31:0] avail, prev, cand, dist_c;
  logic [31:0] ra0, ra1;
  logic [7:0]  rd0, rd1;
  logic        in_acc, hash_load;
  logic [HB-1:0] slot;
  logic          tab_we;
  logic [HB-1:0] tab_waddr;
  logic [31:0]   tab_wdata, tab_rd;
  logic [1:0]    lane;
  logic [8:0]    mlen_m3;
  logic [2:0]    tk_last;
  lzc_pkg::pk_cmd_t  pk_cmd;
  lzc_pkg::pk_stat_t pk_stat;

  assign eff_m = (max_match_r < lzc_pkg::MIN_MATCH) ? lzc_pkg::MIN_MATCH :
                 (max_match_r > lzc_pkg::MATCH_CEIL) ? lzc_pkg::MATCH_CEIL : max_match_r;
  assign eff_b = (tbits_r < lzc_pkg::TBITS_MIN) ? lzc_pkg::TBITS_MIN :
                 (tbits_r > HBV) ? HBV : tbits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_match_r <= lzc_pkg::MATCH_CEIL;
      allow_ext_r <= 1'b1;
      tbits_r     <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lzc_pkg::CFG_MAX_MATCH: max_match_r <= cfg_data;
        lzc_pkg::CFG_ALLOW_EXT: allow_ext_r <= cfg_data[0];
        lzc_pkg::CFG_TBITS:     tbits_r     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != lzc_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  lzc_ring #(.AW(AW)) u_ring (
    .clk(clk), .we(in_acc), .waddr(bytes_r[AW-1:0]), .wdata(in_byte),
    .raddr0(ra0[AW-1:0]), .raddr1(ra1[AW-1:0]), .rdata0(rd0), .rdata1(rd1)
  );

  lzc_hash #(.HB(HB)) u_hash (
    .clk(clk), .load(hash_load), .word(word_r), .tbits(eff_b), .slot(slot)
  );

  assign tab_we    = (state_r == lzc_pkg::S_TWR) || (state_r == lzc_pkg::S_CLR);
  assign tab_waddr = (state_r == lzc_pkg::S_CLR) ? clr_r : slot;
  assign tab_wdata = (state_r == lzc_pkg::S_CLR) ? 32'd0 : scan_r + 32'd1;

  lzc_table #(.AW(HB)) u_table (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(slot), .rdata(tab_rd)
  );

  lzc_packer u_pack (
    .clk(clk), .rst_n(rst_n), .cmd(pk_cmd), .stat(pk_stat),
    .out_valid(out_valid), .out_stall(out_stall), .out_bytes(out_bytes),
    .out_byte_count(out_byte_count), .out_last_of_run(out_last_of_run),
    .out_end_of_stream(out_end_of_stream)
  );

  assign avail   = bytes_r - scan_r;
  assign prev    = tab_rd;
  assign cand    = prev - 32'd1;
  assign dist_c  = scan_r - cand;
  assign lane    = fk_r[1:0] - 2'd1;
  assign mlen_m3 = mlen_r - 9'd3;
  assign tk_last = ext_r ? 3'd4 : 3'd2;
  assign ra1     = scan_r + {23'd0, k_r};

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    bytes_nxt   = bytes_r;
    scan_nxt    = scan_r;
    pend_nxt    = pend_r;
    last_nxt    = last_r;
    fk_nxt      = fk_r;
    word_nxt    = word_r;
    k_nxt       = k_r;
    limit_nxt   = limit_r;
    mlen_nxt    = mlen_r;
    cand_nxt    = cand_r;
    dist_nxt    = dist_r;
    ext_nxt     = ext_r;
    tk_nxt      = tk_r;
    ep_addr_nxt = ep_addr_r;
    ep_cnt_nxt  = ep_cnt_r;
    clr_nxt     = clr_r;
    hash_load   = 1'b0;
    ra0         = scan_r;
    pk_cmd      = '0;
    unique case (state_r)
      lzc_pkg::S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = lzc_pkg::S_IDLE;
        end
      end
      lzc_pkg::S_IDLE: begin
        if (in_acc) begin
          bytes_nxt = bytes_r + 32'd1;
          last_nxt  = in_last_byte;
          state_nxt = lzc_pkg::S_CHECK;
        end
      end
      lzc_pkg::S_CHECK: begin
        fk_nxt = 3'd0;
        if (!last_r) begin
          state_nxt = (avail >= {23'd0, eff_m}) ? lzc_pkg::S_FETCH : lzc_pkg::S_DONE;
        end else if (avail >= 32'd4) begin
          state_nxt = lzc_pkg::S_FETCH;
        end else begin
          // flush the tail as literals
          pend_nxt  = pend_r + avail[7:0];
          scan_nxt  = bytes_r;
          ret_nxt   = lzc_pkg::S_FIN;
          state_nxt = lzc_pkg::S_EP;
        end
      end
      lzc_pkg::S_FETCH: begin
        ra0 = scan_r + {29'd0, fk_r};
        if (fk_r != 3'd0) begin
          word_nxt[lane*8 +: 8] = rd0;
        end
        fk_nxt = fk_r + 3'd1;
        if (fk_r == 3'd4) begin
          state_nxt = lzc_pkg::S_HASH;
        end
      end
      lzc_pkg::S_HASH: begin
        hash_load = 1'b1;
        state_nxt = lzc_pkg::S_TRD;
      end
      lzc_pkg::S_TRD: begin
        state_nxt = lzc_pkg::S_TWR;
      end
      lzc_pkg::S_TWR: begin
        cand_nxt  = cand;
        dist_nxt  = dist_c[15:0];
        limit_nxt = (avail < {23'd0, eff_m}) ? avail[8:0] : eff_m;
        k_nxt     = 9'd0;
        if (prev != 32'd0 && dist_c != 32'd0 && dist_c <= MAXD) begin
          state_nxt = lzc_pkg::S_CISS;
        end else begin
          state_nxt = lzc_pkg::S_LIT;
        end
      end
      lzc_pkg::S_CISS: begin
        ra0       = cand_r + {23'd0, k_r};
        state_nxt = lzc_pkg::S_CCMP;
      end
      lzc_pkg::S_CCMP: begin
        ra0 = cand_r + {23'd0, k_r};
        if (rd0 == rd1) begin
          k_nxt     = k_r + 9'd1;
          state_nxt = (k_r + 9'd1 < limit_r) ? lzc_pkg::S_CISS : lzc_pkg::S_MDEC;
        end else begin
          state_nxt = lzc_pkg::S_MDEC;
        end
      end
      lzc_pkg::S_MDEC: begin
        if (k_r >= lzc_pkg::MIN_MATCH) begin
          if (k_r > lzc_pkg::SHORT_CAP && !allow_ext_r) begin
            mlen_nxt = lzc_pkg::SHORT_CAP;
          end else begin
            mlen_nxt = k_r;
          end
          ext_nxt   = (k_r > lzc_pkg::SHORT_CAP) && allow_ext_r;
          tk_nxt    = 3'd0;
          ret_nxt   = lzc_pkg::S_TOK;
          state_nxt = lzc_pkg::S_EP;
        end else begin
          state_nxt = lzc_pkg::S_LIT;
        end
      end
      lzc_pkg::S_LIT: begin
        scan_nxt = scan_r + 32'd1;
        pend_nxt = pend_r + 8'd1;
        if (pend_r + 8'd1 >= lzc_pkg::RUN_CAP) begin
          ret_nxt   = lzc_pkg::S_CHECK;
          state_nxt = lzc_pkg::S_EP;
        end else begin
          state_nxt = lzc_pkg::S_CHECK;
        end
      end
      lzc_pkg::S_EP: begin
        if (pend_r == 8'd0) begin
          state_nxt = ret_r;
        end else begin
          pk_cmd.byte_v = 1'b1;
          pk_cmd.data   = (pend_r < lzc_pkg::RUN_CAP) ? pend_r : lzc_pkg::RUN_CAP;
          if (pk_stat.byte_rdy) begin
            ep_addr_nxt = scan_r - {24'd0, pend_r};
            ep_cnt_nxt  = pk_cmd.data[6:0];
            state_nxt   = lzc_pkg::S_EP_RD;
          end
        end
      end
      lzc_pkg::S_EP_RD: begin
        ra0       = ep_addr_r;
        state_nxt = lzc_pkg::S_EP_WR;
      end
      lzc_pkg::S_EP_WR: begin
        ra0           = ep_addr_r;
        pk_cmd.byte_v = 1'b1;
        pk_cmd.data   = rd0;
        if (pk_stat.byte_rdy) begin
          ep_addr_nxt = ep_addr_r + 32'd1;
          ep_cnt_nxt  = ep_cnt_r - 7'd1;
          pend_nxt    = pend_r - 8'd1;
          state_nxt   = (ep_cnt_r == 7'd1) ? lzc_pkg::S_EP : lzc_pkg::S_EP_RD;
        end
      end
      lzc_pkg::S_TOK: begin
        pk_cmd.byte_v = 1'b1;
        if (ext_r) begin
          unique case (tk_r)
            3'd0:    pk_cmd.data = lzc_pkg::TOK_EXT;
            3'd1:    pk_cmd.data = mlen_r[7:0];
            3'd2:    pk_cmd.data = {7'd0, mlen_r[8]};
            3'd3:    pk_cmd.data = dist_r[7:0];
            default: pk_cmd.data = dist_r[15:8];
          endcase
        end else begin
          unique case (tk_r)
            3'd0:    pk_cmd.data = lzc_pkg::TOK_SHORT | mlen_m3[7:0];
            3'd1:    pk_cmd.data = dist_r[7:0];
            default: pk_cmd.data = dist_r[15:8];
          endcase
        end
        if (pk_stat.byte_rdy) begin
          tk_nxt = tk_r + 3'd1;
          if (tk_r == tk_last) begin
            scan_nxt  = scan_r + {23'd0, mlen_r};
            state_nxt = lzc_pkg::S_CHECK;
          end
        end
      end
      lzc_pkg::S_FIN: begin
        pk_cmd.flush = 1'b1;
        pk_cmd.eos   = 1'b1;
        if (pk_stat.flush_rdy) begin
          bytes_nxt = 32'd0;
          scan_nxt  = 32'd0;
          pend_nxt  = 8'd0;
          clr_nxt   = '0;
          state_nxt = lzc_pkg::S_CLR;
        end
      end
      lzc_pkg::S_DONE: begin
        if (pk_stat.has_data) begin
          pk_cmd.flush = 1'b1;
          if (pk_stat.flush_rdy) begin
            state_nxt = lzc_pkg::S_IDLE;
          end
        end else begin
          state_nxt = lzc_pkg::S_IDLE;
        end
      end
      default: state_nxt = lzc_pkg::S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzc_pkg::S_CLR;
      ret_r   <= lzc_pkg::S_CHECK;
      bytes_r <= 32'd0;
      scan_r  <= 32'd0;
      pend_r  <= 8'd0;
      last_r  <= 1'b0;
      fk_r    <= 3'd0;
      tk_r    <= 3'd0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      bytes_r <= bytes_nxt;
      scan_r  <= scan_nxt;
      pend_r  <= pend_nxt;
      last_r  <= last_nxt;
      fk_r    <= fk_nxt;
      tk_r    <= tk_nxt;
      clr_r   <= clr_nxt;
    end
    word_r    <= word_nxt;
    k_r       <= k_nxt;
    limit_r   <= limit_nxt;
    mlen_r    <= mlen_nxt;
    cand_r    <= cand_nxt;
    dist_r    <= dist_nxt;
    ext_r     <= ext_nxt;
    ep_addr_r <= ep_addr_nxt;
    ep_cnt_r  <= ep_cnt_nxt;
  end

  `LZC_ASSERT_NOW(a_idle_run_short, state_r == lzc_pkg::S_IDLE, pend_r < lzc_pkg::RUN_CAP)
  `LZC_ASSERT_NOW(a_eos_ends_run, out_valid && out_end_of_stream, out_last_of_run)
  `LZC_ASSERT_NOW(a_count_range, out_valid, out_byte_count != 4'd0 && out_byte_count <= 4'd8)
  `LZC_ASSERT_NEXT(a_accept_checks, in_valid && !in_stall, state_r == lzc_pkg::S_CHECK)

endmodule

// File: src/lzc_ring.sv
// History ring memory: one write port, two registered read ports.
// Depends on nothing but its parameters.
module lzc_ring #(
  parameter int AW = 17
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [7:0]    rdata0,
  output logic [7:0]    rdata1
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// File: src/lzc_table.sv
// Hash table memory: one write port, one registered read port.
// Depends on nothing but its parameters.
module lzc_table #(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/lzc_hash.sv
// Shared multiplicative hash unit: registered 32x32 product, slot select.
// Depends on lzc_pkg for the multiplier constant.
module lzc_hash #(
  parameter int HB = 16
) (
  input  logic          clk,
  input  logic          load,
  input  logic [31:0]   word,
  input  logic [4:0]    tbits,
  output logic [HB-1:0] slot
);

  logic [31:0] prod_r;
  logic [5:0]  sh;
  logic [31:0] shifted;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= 32'(word * lzc_pkg::HASH_MUL);
    end
  end

  assign sh      = 6'd32 - {1'b0, tbits};
  assign shifted = prod_r >> sh;
  assign slot    = shifted[HB-1:0];

endmodule

// File: src/lzc_packer.sv
// Byte packer: gathers bytes into 64-bit little-endian words, output register.
// Depends on lzc_pkg for the command and status structs.
module lzc_packer (
  input  logic              clk,
  input  logic              rst_n,
  input  lzc_pkg::pk_cmd_t  cmd,
  output lzc_pkg::pk_stat_t stat,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       out_bytes,
  output logic [3:0]        out_byte_count,
  output logic              out_last_of_run,
  output logic              out_end_of_stream
);

  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        ov_r, ov_nxt;
  logic [63:0] od_r;
  logic [3:0]  ocnt_r;
  logic        olast_r, oeos_r;
  logic        out_free, load, load_last, load_eos;

  assign out_free       = !ov_r || !out_stall;
  assign stat.byte_rdy  = (cnt_r != 4'd8) || out_free;
  assign stat.flush_rdy = out_free;
  assign stat.has_data  = (cnt_r != 4'd0);

  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    load      = 1'b0;
    load_last = 1'b0;
    load_eos  = 1'b0;
    if (cmd.byte_v && stat.byte_rdy) begin
      priority if (cnt_r == 4'd8) begin
        // hold a full word until we know whether it ends the run
        load    = 1'b1;
        acc_nxt = {56'd0, cmd.data};
        cnt_nxt = 4'd1;
      end else if (cnt_r == 4'd0) begin
        acc_nxt = {56'd0, cmd.data};
        cnt_nxt = 4'd1;
      end else begin
        acc_nxt[cnt_r[2:0]*8 +: 8] = cmd.data;
        cnt_nxt = cnt_r + 4'd1;
      end
    end else if (cmd.flush && stat.flush_rdy) begin
      load      = 1'b1;
      load_last = 1'b1;
      load_eos  = cmd.eos;
      cnt_nxt   = 4'd0;
    end
    if (load) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
    acc_r <= acc_nxt;
    if (load) begin
      od_r    <= acc_r;
      ocnt_r  <= cnt_r;
      olast_r <= load_last;
      oeos_r  <= load_eos;
    end
  end

  assign out_valid         = ov_r;
  assign out_bytes         = od_r;
  assign out_byte_count    = ocnt_r;
  assign out_last_of_run   = olast_r;
  assign out_end_of_stream = oeos_r;

endmodule
